// File: src/mexp_pkg.sv
// types and constants for the modular exponentiation core
// no dependencies

package mexp_pkg;

	localparam int BASE_W = 32;
	localparam int EXP_W  = 64;
	localparam int MODV_W = 32;
	localparam int RES_W  = 32;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [EXP_W-1:0]  exponent;
		logic [MODV_W-1:0] modulus;
	} mexp_in_t;

	typedef struct packed {
		logic [RES_W-1:0] power_result;
		logic             zero_modulus_error;
	} mexp_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

// File: src/mexp_modmul.sv
// shared modular multiplier: one product register, then bit-serial restoring reduction
// depends on mexp_pkg

module mexp_modmul #(
	parameter int W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	input  logic [W-1:0]      m,
	output mexp_pkg::mm_stat_t stat,
	output logic [W-1:0]      r
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(2 * W);
	localparam logic P_IDLE = 1'b0;
	localparam logic P_RED  = 1'b1;

	logic             phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2*W-1:0]   prod_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     m_q;

	logic [2*W-1:0]   prod_c;
	logic [W:0]       trial;
	logic [W+1:0]     diff;
	logic [W-1:0]     rem_next;
	logic             last;

	assign prod_c   = {{W{1'b0}}, a} * {{W{1'b0}}, b};
	assign trial    = {rem_q, prod_q[2*W-1]};
	assign diff     = {1'b0, trial} - {2'b00, m_q};
	assign rem_next = diff[W+1] ? trial[W-1:0] : diff[W-1:0];
	assign last     = (cnt_q == CNT_W'(2 * W - 1));

	assign stat.busy = (phase_q == P_RED);
	assign stat.done = (phase_q == P_RED) && last;
	assign r         = rem_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= P_RED;
						cnt_q   <= '0;
					end
				end
				P_RED: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) begin
						phase_q <= P_IDLE;
					end
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == P_IDLE && start) begin
			prod_q <= prod_c;
			rem_q  <= '0;
			m_q    <= m;
		end else if (phase_q == P_RED) begin
			prod_q <= {prod_q[2*W-2:0], 1'b0};
			rem_q  <= rem_next;
		end
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> phase_q == P_IDLE)
		else $error("modmul started while busy");

	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_RED |-> rem_q < m_q)
		else $error("partial remainder not below modulus");

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> phase_q == P_IDLE)
		else $error("modmul did not return to idle after done");
`endif

endmodule

// File: src/modular_exponentiation_core.sv
// modular exponentiation core, right-to-left square-and-multiply
// depends on mexp_pkg and mexp_modmul
//
// usage: a transfer on req (valid/ready) carries base, exponent and modulus;
// one transfer on rsp (valid/ready) returns base^exponent mod modulus.
// req_ready is high only while the core is idle; one item is worked at a time.
// each modular product goes through one shared multiplier and a bit-serial
// reduction. a zero exponent or zero modulus issues no product and goes
// straight from the step state to the done state.
// a zero modulus returns zero with zero_modulus_error set.
// the result sits in an output register: a new request is accepted while it
// waits, and the core holds its next result until rsp_ready frees the register.
// reset clears the sequencer and drops rsp_valid; any item in flight is lost.

module modular_exponentiation_core #(
	parameter int MOD_WIDTH = 32,
	parameter int EXP_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mexp_pkg::mexp_in_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mexp_pkg::mexp_out_t rsp
);
	import mexp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_STEP = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SQR  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]           state_q;
	logic                 rsp_valid_q;
	mexp_out_t            rsp_q;
	logic [MOD_WIDTH-1:0] base_q;
	logic [MOD_WIDTH-1:0] mod_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic                 err_q;

	logic                 req_xfer;
	logic                 out_load;
	logic                 mm_start;
	logic [MOD_WIDTH-1:0] mm_a;
	logic [MOD_WIDTH-1:0] mm_r;
	mm_stat_t             mm_stat;

	assign req_ready = (state_q == ST_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign out_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);
	assign mm_start  = (state_q == ST_STEP) && !err_q && (exp_q != '0);
	assign mm_a      = exp_q[0] ? acc_q : base_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	mexp_modmul #(
		.W(MOD_WIDTH)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (base_q),
		.m      (mod_q),
		.stat   (mm_stat),
		.r      (mm_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (err_q || exp_q == '0) begin
						state_q <= ST_DONE;
					end else if (exp_q[0]) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_MUL, ST_SQR: begin
					if (mm_stat.done) begin
						state_q <= ST_STEP;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			base_q <= req.base[MOD_WIDTH-1:0];
			exp_q  <= req.exponent[EXP_WIDTH-1:0];
			mod_q  <= req.modulus[MOD_WIDTH-1:0];
			acc_q  <= MOD_WIDTH'(1);
			err_q  <= (req.modulus[MOD_WIDTH-1:0] == '0);
		end
		if (state_q == ST_MUL && mm_stat.done) begin
			acc_q    <= mm_r;
			exp_q[0] <= 1'b0;
		end
		if (state_q == ST_SQR && mm_stat.done) begin
			base_q <= mm_r;
			exp_q  <= exp_q >> 1;
		end
		if (out_load) begin
			rsp_q.power_result       <= err_q ? '0 : RES_W'(acc_q);
			rsp_q.zero_modulus_error <= err_q;
		end
	end

`ifndef SYNTHESIS
	a_unit_busy_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_SQR) |-> mm_stat.busy)
		else $error("sequencer waits on an idle multiplier");

	a_unit_idle_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mm_stat.busy)
		else $error("multiplier busy while sequencer idle");

	a_err_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.zero_modulus_error) |-> rsp.power_result == '0)
		else $error("zero modulus result not zero");

	a_no_op_on_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && mod_q == '0) |-> !mm_start)
		else $error("product issued with zero modulus");
`endif

endmodule
